// ----- hdl/vr3d_pkg.sv -----
// ----------------------------------------------------------------------------
// vr3d_pkg
// Shared widths and types for the 3D vector refraction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vr3d_pkg;

   // Field widths of the channels
   localparam int VEC_W = 16;
   localparam int ETA_W = 16;

   // Operands that travel down the pipeline next to the arithmetic
   typedef struct packed {
      logic [2:0][VEC_W-1:0] inc;
      logic [2:0][VEC_W-1:0] nrm;
      logic [ETA_W-1:0]      eta;
   } vr3d_src_type;

endpackage

`default_nettype wire

// ----- hdl/vr3d_req_if.sv -----
// ----------------------------------------------------------------------------
// vr3d_req_if
// Input channel: incident vector, surface normal and index ratio.
// ----------------------------------------------------------------------------
`default_nettype none

interface vr3d_req_if;
   import vr3d_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VEC_W-1:0] incident_x;
   logic signed [VEC_W-1:0] incident_y;
   logic signed [VEC_W-1:0] incident_z;
   logic signed [VEC_W-1:0] normal_x;
   logic signed [VEC_W-1:0] normal_y;
   logic signed [VEC_W-1:0] normal_z;
   logic [ETA_W-1:0]        index_ratio;

   modport source (
      output valid, incident_x, incident_y, incident_z,
      output normal_x, normal_y, normal_z, index_ratio,
      input  ready
   );

   modport sink (
      input  valid, incident_x, incident_y, incident_z,
      input  normal_x, normal_y, normal_z, index_ratio,
      output ready
   );

endinterface

`default_nettype wire

// ----- hdl/vr3d_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vr3d_rsp_if
// Result channel: refracted vector and total reflection flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vr3d_rsp_if;
   import vr3d_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VEC_W-1:0] refracted_x;
   logic signed [VEC_W-1:0] refracted_y;
   logic signed [VEC_W-1:0] refracted_z;
   logic                    total_reflection;

   modport source (
      output valid, refracted_x, refracted_y, refracted_z, total_reflection,
      input  ready
   );

   modport sink (
      input  valid, refracted_x, refracted_y, refracted_z, total_reflection,
      output ready
   );

endinterface

`default_nettype wire

// ----- hdl/vr3d_isqrt.sv -----
// ----------------------------------------------------------------------------
// vr3d_isqrt
// Pipelined integer square root, floor(sqrt(x)), one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vr3d_isqrt #(
   parameter int ROOT_W = 26
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic [ROOT_W-1:0]     root
);

   localparam int XW = 2 * ROOT_W;

   logic [ROOT_W+1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [XW-1:0]     x_ff    [ROOT_W];

   // Restoring square root: bring down two radicand bits, try root*4+1
   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      logic [ROOT_W+1:0] rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [XW-1:0]     x_prev;
      logic [ROOT_W+1:0] rem_sh;
      logic [ROOT_W+1:0] trial;
      logic [ROOT_W+1:0] rem_in;
      logic [ROOT_W-1:0] root_in;

      if (g == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign x_prev    = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign x_prev    = x_ff[g-1];
      end

      always_comb begin
         rem_sh = {rem_prev[ROOT_W-1:0], x_prev[XW-1 -: 2]};
         trial  = {root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            x_ff[g]    <= x_prev << 2;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

`default_nettype wire

// ----- hdl/vector_refract_3d.sv -----
// ----------------------------------------------------------------------------
// vector_refract_3d
// Refraction of an incident vector at a surface, fixed point with
// FRAC_BITS fraction bits: d = n.i, k = 1 - eta^2 (1 - d^2), and
// r = i*eta - n*(eta*d + sqrt(k)), or zero with a flag when k < 0.
// ----------------------------------------------------------------------------
//
//  channel    direction  handshake      payload
//  req_chan   in         valid / ready  incident_x/y/z, normal_x/y/z, index_ratio
//  rsp_chan   out        valid / ready  refracted_x/y/z, total_reflection
//
//  One item per clock while the output register is not held. ROOT_W is the
//  root width of the square root pipeline (26 at FRAC_BITS = 14).
//  The whole pipeline advances whenever the output register is empty or
//  taken; a held result stalls every stage and req_chan.ready drops.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_refract_3d #(
   parameter int FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   vr3d_req_if.sink    req_chan,
   vr3d_rsp_if.source  rsp_chan
);

   import vr3d_pkg::*;

   // Widths, derived from the fraction width and the package field widths
   localparam int F      = FRAC_BITS;
   localparam int HALF   = 1 << (F - 1);
   localparam int ONE    = 1 << F;
   localparam int PW     = 2 * VEC_W;
   localparam int SW     = PW + 2;
   localparam int DT     = SW + 2;
   localparam int DW     = DT - F;
   localparam int DD_NAT = 2 * DW + 1;
   localparam int DDT    = (DD_NAT > F + 2) ? DD_NAT : F + 2;
   localparam int DSQW   = DDT - F;
   localparam int EEW    = 2 * ETA_W;
   localparam int ESQW   = EEW + 1 - F;
   localparam int MPW    = ESQW + DSQW;
   localparam int PR_NAT = MPW + 1;
   localparam int PRT    = (PR_NAT > F + 2) ? PR_NAT : F + 2;
   localparam int PRW    = PRT - F;
   localparam int KA     = (F + 2 > ESQW + 1) ? F + 2 : ESQW + 1;
   localparam int KB     = (KA > PRW + 1) ? KA : PRW + 1;
   localparam int KW     = KB + 1;
   localparam int ROOT_W = (KW + F) / 2;
   localparam int XW     = 2 * ROOT_W;
   localparam int EDW    = DW + ETA_W + 1;
   localparam int EDT    = (EDW + 1 > F + 2) ? EDW + 1 : F + 2;
   localparam int EDRW   = EDT - F;
   localparam int CA     = (EDRW > ROOT_W + 1) ? EDRW : ROOT_W + 1;
   localparam int CW     = CA + 1;
   localparam int IEW    = VEC_W + ETA_W + 1;
   localparam int NCW    = VEC_W + CW;
   localparam int OW     = ((IEW > NCW) ? IEW : NCW) + 1;
   localparam int OT     = OW + 1;
   localparam int SAT_HI = (1 << (VEC_W - 1)) - 1;
   localparam int SAT_LO = -(1 << (VEC_W - 1));

   // Stage positions in the valid line
   localparam int ST_S7  = 6 + ROOT_W;
   localparam int ST_OUT = 8 + ROOT_W;
   localparam int NST    = ST_OUT + 1;

   logic adv;
   logic vld_ff [NST];

   assign adv            = !vld_ff[ST_OUT] || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_chan.valid;
         for (int s = 1; s < NST; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // Operand line, stage 1 through stage 7
   vr3d_src_type src_in;
   vr3d_src_type src_ff [ST_S7 + 1];

   assign src_in.inc = {req_chan.incident_z, req_chan.incident_y, req_chan.incident_x};
   assign src_in.nrm = {req_chan.normal_z, req_chan.normal_y, req_chan.normal_x};
   assign src_in.eta = req_chan.index_ratio;

   always_ff @(posedge clock) begin
      if (adv) begin
         src_ff[0] <= src_in;
         for (int s = 1; s <= ST_S7; s++) begin
            src_ff[s] <= src_ff[s-1];
         end
      end
   end

   // Stage 1: component products and eta squared
   logic signed [PW-1:0] p_in [3];
   logic signed [PW-1:0] p_ff [3];
   logic [EEW-1:0]       ee_in;
   logic [EEW-1:0]       ee_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         p_in[j] = PW'($signed(src_in.nrm[j])) * PW'($signed(src_in.inc[j]));
      end
      ee_in = EEW'(src_in.eta) * EEW'(src_in.eta);
   end

   // Stage 2: dot product rounded, eta squared rounded
   logic signed [SW-1:0] dw_sum;
   logic signed [DT-1:0] dw_rnd;
   logic signed [DW-1:0] d_in;
   logic signed [DW-1:0] d_ff;
   logic [EEW:0]         ee_rnd;
   logic [ESQW-1:0]      esq_in;
   logic [ESQW-1:0]      esq2_ff;

   always_comb begin
      dw_sum = SW'(p_ff[0]) + SW'(p_ff[1]) + SW'(p_ff[2]);
      dw_rnd = DT'(dw_sum) + DT'(HALF);
      d_in   = DW'(dw_rnd >>> F);
      ee_rnd = {1'b0, ee_ff} + (EEW+1)'(HALF);
      esq_in = ESQW'(ee_rnd >> F);
   end

   // Stage 3: d squared and eta times d
   logic signed [2*DW-1:0] dd_prod;
   logic [2*DW-1:0]        dd_ff;
   logic signed [EDW-1:0]  ed_in;
   logic signed [EDW-1:0]  ed_ff;
   logic [ESQW-1:0]        esq3_ff;

   always_comb begin
      dd_prod = (2*DW)'(d_ff) * (2*DW)'(d_ff);
      ed_in   = EDW'($signed({1'b0, src_ff[1].eta})) * EDW'(d_ff);
   end

   // Stage 4: round both products
   logic [DDT-1:0]         dd_rnd;
   logic [DSQW-1:0]        dsq_in;
   logic [DSQW-1:0]        dsq_ff;
   logic signed [EDT-1:0]  ed_rnd;
   logic signed [EDRW-1:0] edr_in;
   logic [ESQW-1:0]        esq4_ff;

   always_comb begin
      dd_rnd = DDT'(dd_ff) + DDT'(HALF);
      dsq_in = DSQW'(dd_rnd >> F);
      ed_rnd = EDT'(ed_ff) + EDT'(HALF);
      edr_in = EDRW'(ed_rnd >>> F);
   end

   // Stage 5: eta^2 * d^2
   logic [MPW-1:0]  pr_in;
   logic [MPW-1:0]  pr_ff;
   logic [ESQW-1:0] esq5_ff;

   assign pr_in = MPW'(esq4_ff) * MPW'(dsq_ff);

   // Stage 6: k = 1 - eta^2 + eta^2 d^2
   logic [PRT-1:0]       pr_rnd;
   logic [PRW-1:0]       prr;
   logic signed [KW-1:0] k_in;
   logic signed [KW-1:0] k_ff;

   always_comb begin
      pr_rnd = PRT'(pr_ff) + PRT'(HALF);
      prr    = PRW'(pr_rnd >> F);
      k_in   = KW'(ONE) - KW'($signed({1'b0, esq5_ff}))
               + KW'($signed({1'b0, prr}));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in;
         ee_ff   <= ee_in;
         d_ff    <= d_in;
         esq2_ff <= esq_in;
         dd_ff   <= dd_prod;
         ed_ff   <= ed_in;
         esq3_ff <= esq2_ff;
         dsq_ff  <= dsq_in;
         esq4_ff <= esq3_ff;
         pr_ff   <= pr_in;
         esq5_ff <= esq4_ff;
         k_ff    <= k_in;
      end
   end

   // Square root of k with F fraction bits; zero radicand on reflection
   logic              tir6;
   logic [XW-1:0]     radicand;
   logic [ROOT_W-1:0] root;

   assign tir6     = k_ff[KW-1];
   assign radicand = tir6 ? '0 : (XW'(k_ff[KW-2:0]) << F);

   vr3d_isqrt #(
      .ROOT_W (ROOT_W)
   ) u_isqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (radicand),
      .root     (root)
   );

   // Rounded eta*d and reflection flag alongside the root pipeline
   logic signed [EDRW-1:0] edr_ff [3:ST_S7-1];
   logic                   tir_ff [6:ST_OUT-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         edr_ff[3] <= edr_in;
         for (int s = 4; s < ST_S7; s++) begin
            edr_ff[s] <= edr_ff[s-1];
         end
         tir_ff[6] <= tir6;
         for (int s = 7; s < ST_OUT; s++) begin
            tir_ff[s] <= tir_ff[s-1];
         end
      end
   end

   // Stage 7: c = round(eta*d) + sqrt(k)
   logic signed [CW-1:0] c_in;
   logic signed [CW-1:0] c_ff;

   assign c_in = CW'($signed({1'b0, root})) + CW'(edr_ff[ST_S7-1]);

   // Stage 8: i*eta and n*c per component
   logic signed [IEW-1:0] ie_in [3];
   logic signed [IEW-1:0] ie_ff [3];
   logic signed [NCW-1:0] nc_in [3];
   logic signed [NCW-1:0] nc_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ie_in[j] = IEW'($signed(src_ff[ST_S7].inc[j]))
                    * IEW'($signed({1'b0, src_ff[ST_S7].eta}));
         nc_in[j] = NCW'($signed(src_ff[ST_S7].nrm[j])) * NCW'(c_ff);
      end
   end

   // Stage 9: difference, round, saturate, zero on total reflection
   logic signed [OW-1:0]    diff  [3];
   logic signed [OT-1:0]    drnd  [3];
   logic signed [OT-1:0]    dres  [3];
   logic signed [VEC_W-1:0] res_in [3];
   logic signed [VEC_W-1:0] res_ff [3];
   logic                    tir_out_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         diff[j] = OW'(ie_ff[j]) - OW'(nc_ff[j]);
         drnd[j] = OT'(diff[j]) + OT'(HALF);
         dres[j] = drnd[j] >>> F;
         if (tir_ff[ST_OUT-1]) begin
            res_in[j] = '0;
         end else if (dres[j] > OT'(SAT_HI)) begin
            res_in[j] = VEC_W'(SAT_HI);
         end else if (dres[j] < OT'(SAT_LO)) begin
            res_in[j] = VEC_W'(SAT_LO);
         end else begin
            res_in[j] = VEC_W'(dres[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff       <= c_in;
         ie_ff      <= ie_in;
         nc_ff      <= nc_in;
         res_ff     <= res_in;
         tir_out_ff <= tir_ff[ST_OUT-1];
      end
   end

   assign rsp_chan.valid            = vld_ff[ST_OUT];
   assign rsp_chan.refracted_x      = res_ff[0];
   assign rsp_chan.refracted_y      = res_ff[1];
   assign rsp_chan.refracted_z      = res_ff[2];
   assign rsp_chan.total_reflection = tir_out_ff;

   // Checks
   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.total_reflection |->
         rsp_chan.refracted_x == '0 && rsp_chan.refracted_y == '0 &&
         rsp_chan.refracted_z == '0)
      else $error("reflected item carries a nonzero vector");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken while the output is held");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted item missing from first stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
